// File: rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the task timing statistics table
// Command and status codes, table geometry and the divider request and
// response structs.
// ----------------------------------------------------------------------------
package tts_pkg;

   // table geometry
   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // divider geometry: 64-bit dividend, 32-bit divisor, one bit a cycle
   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // command codes
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_NEW  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   // full-scale load value
   localparam logic [6:0] LOAD_FULL = 7'd100;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/core/task_timing_stats_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_timing_stats_table: execution-time statistics table keyed by task
// Records run times per task key, reports per-task max/average/count and the
// summed load as a percentage of ticks since the last clear.
// ----------------------------------------------------------------------------
// One request word at a time. A clear, or a load with zero elapsed ticks,
// goes straight to the hand-off state. A record or read scans the 16 slots
// one per cycle, stopping at a hit; a miss, a new entry or a full table is
// known after the last slot. A hit computes the average on the shared 64-bit
// restoring divider (64 divider steps plus launch, load and hand-off); when
// the run count has wrapped to zero the divider is skipped. A load sums the
// slot totals over the 16 slots and, unless the sum reaches the elapsed
// ticks, runs the same divider; else it clamps to full scale. req_stall
// stays high from acceptance until the result word has been loaded into the
// output register; a new request is taken while that result word still
// waits on rsp_stall.
// ----------------------------------------------------------------------------
module task_timing_stats_table (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_task_key,
   input  logic [31:0] req_start_tick,
   input  logic [31:0] req_now_tick,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_max_time,
   output logic [31:0] rsp_avg_time,
   output logic [31:0] rsp_run_count,
   output logic [6:0]  rsp_load_percent
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_STATS   = 3'd2;
   localparam logic [2:0] S_SUM     = 3'd3;
   localparam logic [2:0] S_LOADCHK = 3'd4;
   localparam logic [2:0] S_DIV     = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   localparam int LAST = tts_pkg::SLOTS - 1;

   // slot storage
   logic [tts_pkg::SLOTS-1:0] valid_ff, valid_in;
   logic [31:0]               slot_key_ff   [tts_pkg::SLOTS];
   logic [31:0]               slot_max_ff   [tts_pkg::SLOTS];
   logic [63:0]               slot_total_ff [tts_pkg::SLOTS];
   logic [31:0]               slot_count_ff [tts_pkg::SLOTS];

   // slot write port
   logic                      wr_en;
   logic [tts_pkg::SLOT_W-1:0] wr_idx;
   logic [31:0]               wr_key, wr_max, wr_count;
   logic [63:0]               wr_total;

   // sequencer and working registers
   logic [2:0]                state_ff, state_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic [31:0]               key_ff, key_in;
   logic [31:0]               delta_ff, delta_in;
   logic [31:0]               elapsed_ff, elapsed_in;
   logic [31:0]               epoch_ff, epoch_in;
   logic [tts_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic                      free_ok_ff, free_ok_in;
   logic [tts_pkg::SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [63:0]               sum_ff, sum_in;

   // result being built
   logic [1:0]                res_status_ff, res_status_in;
   logic [31:0]               res_max_ff, res_max_in;
   logic [31:0]               res_avg_ff, res_avg_in;
   logic [31:0]               res_count_ff, res_count_in;
   logic [6:0]                res_load_ff, res_load_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [31:0]               rsp_max_ff, rsp_max_in;
   logic [31:0]               rsp_avg_ff, rsp_avg_in;
   logic [31:0]               rsp_count_ff, rsp_count_in;
   logic [6:0]                rsp_load_ff, rsp_load_in;

   // divider request
   logic                      div_start_ff, div_start_in;
   logic [63:0]               div_num_ff, div_num_in;
   logic [31:0]               div_den_ff, div_den_in;

   tts_pkg::div_req_type      div_req;
   tts_pkg::div_rsp_type      div_rsp;

   // scratch
   logic                      req_take;
   logic                      rsp_free;
   logic                      is_last;
   logic                      hit;
   logic [31:0]               rd_max, rd_count;
   logic [63:0]               rd_total;
   logic [31:0]               new_max, new_count;
   logic [63:0]               new_total;
   logic [64:0]               sum_wide;
   logic [63:0]               scaled;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (idx_ff == tts_pkg::SLOT_W'(LAST));
   assign hit       = valid_ff[idx_ff] && (slot_key_ff[idx_ff] == key_ff);

   assign rd_max    = slot_max_ff[idx_ff];
   assign rd_total  = slot_total_ff[idx_ff];
   assign rd_count  = slot_count_ff[idx_ff];
   assign new_max   = (delta_ff > rd_max) ? delta_ff : rd_max;
   assign new_total = rd_total + {32'd0, delta_ff};
   assign new_count = rd_count + 32'd1;

   // saturating accumulate and times-100 as shift-add
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, rd_total};
   assign scaled    = ({32'd0, sum_ff[31:0]} << 6) + ({32'd0, sum_ff[31:0]} << 5)
                    + ({32'd0, sum_ff[31:0]} << 2);

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = div_num_ff;
   assign div_req.divisor  = div_den_ff;

   tts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      delta_in      = delta_ff;
      elapsed_in    = elapsed_ff;
      epoch_in      = epoch_ff;
      idx_in        = idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      sum_in        = sum_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_max_in    = res_max_ff;
      res_avg_in    = res_avg_ff;
      res_count_in  = res_count_ff;
      res_load_in   = res_load_ff;
      div_start_in  = 1'b0;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      wr_en         = 1'b0;
      wr_idx        = idx_ff;
      wr_key        = key_ff;
      wr_max        = new_max;
      wr_total      = new_total;
      wr_count      = new_count;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_load_in   = rsp_load_ff;

      unique case (state_ff)
         S_IDLE: begin
            // latch the request and start a fresh result
            if (req_take) begin
               cmd_in        = req_command;
               key_in        = req_task_key;
               delta_in      = req_start_tick == req_now_tick ? 32'd0
                             : req_now_tick - req_start_tick;
               elapsed_in    = req_now_tick - epoch_ff;
               idx_in        = '0;
               free_ok_in    = 1'b0;
               sum_in        = '0;
               res_status_in = tts_pkg::ST_DONE;
               res_max_in    = '0;
               res_avg_in    = '0;
               res_count_in  = '0;
               res_load_in   = '0;
               unique case (req_command)
                  tts_pkg::CMD_RECORD, tts_pkg::CMD_READ: state_in = S_SCAN;
                  tts_pkg::CMD_LOAD: begin
                     state_in = (req_now_tick == epoch_ff) ? S_DONE : S_SUM;
                  end
                  tts_pkg::CMD_CLEAR: begin
                     valid_in = '0;
                     epoch_in = req_now_tick;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_SCAN: begin
            // compare one slot a cycle, remember the lowest free one
            if (hit) begin
               state_in = S_STATS;
            end else begin
               if (!valid_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (is_last) begin
                  state_in = S_DONE;
                  if (cmd_ff == tts_pkg::CMD_READ) begin
                     res_status_in = tts_pkg::ST_MISS;
                  end else if (free_ok_in) begin
                     // claim the free slot
                     wr_en              = 1'b1;
                     wr_idx             = free_idx_in;
                     wr_max             = delta_ff;
                     wr_total           = {32'd0, delta_ff};
                     wr_count           = 32'd1;
                     valid_in[free_idx_in] = 1'b1;
                     res_status_in      = tts_pkg::ST_NEW;
                     res_max_in         = delta_ff;
                     res_avg_in         = delta_ff;
                     res_count_in       = 32'd1;
                  end else begin
                     res_status_in = tts_pkg::ST_FULL;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_STATS: begin
            // update on record, then launch the average
            if (cmd_ff == tts_pkg::CMD_RECORD) begin
               wr_en        = 1'b1;
               res_max_in   = new_max;
               res_count_in = new_count;
               div_num_in   = new_total;
               div_den_in   = new_count;
            end else begin
               res_max_in   = rd_max;
               res_count_in = rd_count;
               div_num_in   = rd_total;
               div_den_in   = rd_count;
            end
            if (div_den_in == 32'd0) begin
               res_avg_in = '0;
               state_in   = S_DONE;
            end else begin
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end
         end

         S_SUM: begin
            // accumulate valid totals, saturating
            if (valid_ff[idx_ff]) begin
               sum_in = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
            end
            if (is_last) begin
               state_in = S_LOADCHK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_LOADCHK: begin
            // clamp or divide the scaled sum by the elapsed ticks
            if (sum_ff >= {32'd0, elapsed_ff}) begin
               res_load_in = tts_pkg::LOAD_FULL;
               state_in    = S_DONE;
            end else begin
               div_num_in   = scaled;
               div_den_in   = elapsed_ff;
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end
         end

         S_DIV: begin
            // wait for the quotient
            if (div_rsp.done) begin
               if (cmd_ff == tts_pkg::CMD_LOAD) begin
                  res_load_in = div_rsp.quotient[6:0];
               end else begin
                  res_avg_in = div_rsp.quotient[31:0];
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hand the word to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_max_in    = res_max_ff;
               rsp_avg_in    = res_avg_ff;
               rsp_count_in  = res_count_ff;
               rsp_load_in   = res_load_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= div_start_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      delta_ff      <= delta_in;
      elapsed_ff    <= elapsed_in;
      idx_ff        <= idx_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      sum_ff        <= sum_in;
      res_status_ff <= res_status_in;
      res_max_ff    <= res_max_in;
      res_avg_ff    <= res_avg_in;
      res_count_ff  <= res_count_in;
      res_load_ff   <= res_load_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
      rsp_status_ff <= rsp_status_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_load_ff   <= rsp_load_in;
   end

   // slot storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_key_ff[wr_idx]   <= wr_key;
         slot_max_ff[wr_idx]   <= wr_max;
         slot_total_ff[wr_idx] <= wr_total;
         slot_count_ff[wr_idx] <= wr_count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_max_time     = rsp_max_ff;
   assign rsp_avg_time     = rsp_avg_ff;
   assign rsp_run_count    = rsp_count_ff;
   assign rsp_load_percent = rsp_load_ff;

   // a result word appears only out of the hand-off state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result word raised outside hand-off");

   // load never exceeds full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_load_ff <= tts_pkg::LOAD_FULL)
      else $error("load percent above full scale");

   // the divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside the wait state");

   // a divide is launched only with a nonzero divisor
   assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> div_den_ff != 32'd0)
      else $error("divide launched with zero divisor");

endmodule

// File: rtl/core/tts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a nonzero 32-bit divisor, one
// quotient bit a cycle. Pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module tts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tts_pkg::div_req_type div_req,
   output tts_pkg::div_rsp_type div_rsp
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [tts_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]                   quo_ff, quo_in;
   logic [31:0]                   rem_ff, rem_in;
   logic [31:0]                   den_ff, den_in;
   logic [32:0]                   trial;
   logic [32:0]                   diff;

   // one restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      diff    = trial - {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = div_req.dividend;
         rem_in = '0;
         den_in = div_req.divisor;
      end else if (run_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tts_pkg::DIV_CNT_W'(tts_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
